[sv/pss_pkg.sv]
// types and constants shared by the shutdown sequencer modules
package pss_pkg;

	// event kinds carried on the input tuser
	typedef enum logic [1:0] {
		ACT_SWITCH = 2'd0,
		ACT_FRAME  = 2'd1,
		ACT_POLL   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_RUNNING   = 2'd0,
		MODE_QUIESCING = 2'd1,
		MODE_FLUSHING  = 2'd2,
		MODE_ASLEEP    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		MSG_NONE     = 3'd0,
		MSG_SHUTDOWN = 3'd1,
		MSG_SLEEP    = 3'd2,
		MSG_ABORT    = 3'd3,
		MSG_WAKE     = 3'd4
	} msg_t;

	// configuration register indexes
	localparam logic [2:0] CFG_DEBOUNCE    = 3'd0;
	localparam logic [2:0] CFG_SAVE_TMO    = 3'd1;
	localparam logic [2:0] CFG_FLUSH_TMO   = 3'd2;
	localparam logic [2:0] CFG_REPLY_CODE  = 3'd3;
	localparam logic [2:0] CFG_FAILED_CODE = 3'd4;
	localparam logic [2:0] CFG_SWITCH_RST  = 3'd5;

	localparam logic [15:0] RST_DEBOUNCE    = 16'd50;
	localparam logic [15:0] RST_SAVE_TMO    = 16'd2000;
	localparam logic [15:0] RST_FLUSH_TMO   = 16'd500;
	localparam logic [6:0]  RST_REPLY_CODE  = 7'd96;
	localparam logic [7:0]  RST_FAILED_CODE = 8'd255;
	localparam logic        RST_SWITCH      = 1'b1;

	// power frame class
	localparam logic [7:0] CLASS_MASK  = 8'hF0;
	localparam logic [7:0] CLASS_POWER = 8'h60;

	typedef struct packed {
		action_t    action;
		logic [31:0] now_time;
		logic        switch_level;
		logic [7:0]  frame_kind;
		logic [7:0]  frame_length;
		logic [7:0]  frame_first_byte;
		logic        link_up;
		logic        send_ok;
		logic        tx_empty;
	} event_t;

	typedef struct packed {
		logic [15:0] debounce_time;
		logic [15:0] save_timeout;
		logic [15:0] flush_timeout;
		logic [6:0]  saved_reply_code;
		logic [7:0]  save_failed_code;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic        switch_stable;
		logic        switch_last_raw;
		logic        first_sample_seen;
		logic [31:0] raw_change_time;
		logic [31:0] phase_start_time;
		logic        reply_seen;
		logic        request_sent;
		logic [7:0]  last_status;
		logic [15:0] shutdowns;
		logic [15:0] aborts;
		logic [15:0] save_tmo_cnt;
	} state_t;

	// sequencer state after reset
	localparam state_t ST_RESET = '{
		mode:              MODE_RUNNING,
		switch_stable:     RST_SWITCH,
		switch_last_raw:   RST_SWITCH,
		first_sample_seen: 1'b0,
		raw_change_time:   32'd0,
		phase_start_time:  32'd0,
		reply_seen:        1'b0,
		request_sent:      1'b0,
		last_status:       8'd0,
		shutdowns:         16'd0,
		aborts:            16'd0,
		save_tmo_cnt:      16'd0
	};

	typedef struct packed {
		logic        frame_claimed;
		msg_t        message_out;
		logic        quiesce_strobe;
		logic        save_strobe;
		logic        resume_strobe;
		mode_t       power_state;
		logic [7:0]  save_status;
		logic [15:0] shutdown_count;
		logic [15:0] abort_count;
		logic [15:0] timeout_count;
	} result_t;

endpackage

[sv/pss_step.sv]
// next-state and result logic for one event of the shutdown sequencer
module pss_step (
	input  pss_pkg::event_t  ev,
	input  pss_pkg::cfg_t    cfg,
	input  pss_pkg::state_t  st,
	output pss_pkg::state_t  st_nx,
	output pss_pkg::result_t res
);
	import pss_pkg::*;

	logic        is_poll;
	logic        is_frame;
	logic        is_switch;
	logic [31:0] since_phase;
	logic [31:0] since_raw;
	logic [31:0] raw_ref;
	logic        r_start;
	logic        q_abort;
	logic        q_flush;
	logic        q_resend;
	logic        q_tmo;
	logic        f_wake;
	logic        f_sleep;
	logic        a_wake;
	logic        claimed;
	mode_t       mode_nx;

	assign is_poll   = (ev.action == ACT_POLL);
	assign is_frame  = (ev.action == ACT_FRAME);
	assign is_switch = (ev.action == ACT_SWITCH);

	assign since_phase = ev.now_time - st.phase_start_time;
	// first sample ever starts the hold time at its own timestamp
	assign raw_ref   = st.first_sample_seen ? st.raw_change_time : ev.now_time;
	assign since_raw = ev.now_time - raw_ref;

	assign r_start  = is_poll && (st.mode == MODE_RUNNING) && !st.switch_stable;
	assign q_abort  = is_poll && (st.mode == MODE_QUIESCING) && st.switch_stable;
	assign q_flush  = is_poll && (st.mode == MODE_QUIESCING) && !st.switch_stable
		&& (st.reply_seen || !ev.link_up);
	assign q_resend = is_poll && (st.mode == MODE_QUIESCING) && !st.switch_stable
		&& !st.reply_seen && ev.link_up && !st.request_sent;
	assign q_tmo    = is_poll && (st.mode == MODE_QUIESCING) && !st.switch_stable
		&& !st.reply_seen && ev.link_up && st.request_sent
		&& (since_phase >= {16'd0, cfg.save_timeout});
	assign f_wake   = is_poll && (st.mode == MODE_FLUSHING) && st.switch_stable;
	assign f_sleep  = is_poll && (st.mode == MODE_FLUSHING) && !st.switch_stable
		&& (ev.tx_empty || (since_phase >= {16'd0, cfg.flush_timeout}));
	assign a_wake   = is_poll && (st.mode == MODE_ASLEEP) && st.switch_stable;

	assign claimed = is_frame && ((ev.frame_kind & CLASS_MASK) == CLASS_POWER);

	// power state transitions
	always_comb begin
		mode_nx = st.mode;
		unique case (st.mode)
			MODE_RUNNING: begin
				if (r_start) mode_nx = MODE_QUIESCING;
			end
			MODE_QUIESCING: begin
				if (q_abort) mode_nx = MODE_RUNNING;
				else if (q_flush || q_tmo) mode_nx = MODE_FLUSHING;
			end
			MODE_FLUSHING: begin
				if (f_wake) mode_nx = MODE_RUNNING;
				else if (f_sleep) mode_nx = MODE_ASLEEP;
			end
			MODE_ASLEEP: begin
				if (a_wake) mode_nx = MODE_RUNNING;
			end
			default: mode_nx = st.mode;
		endcase
	end

	// strobes, messages and the remaining state
	always_comb begin
		st_nx      = st;
		st_nx.mode = mode_nx;
		res        = '0;
		res.message_out = MSG_NONE;

		if (is_switch) begin
			st_nx.first_sample_seen = 1'b1;
			st_nx.raw_change_time   = raw_ref;
			if (ev.switch_level != st.switch_last_raw) begin
				st_nx.switch_last_raw = ev.switch_level;
				st_nx.raw_change_time = ev.now_time;
			end else if ((ev.switch_level != st.switch_stable)
				&& (since_raw >= {16'd0, cfg.debounce_time})) begin
				st_nx.switch_stable = ev.switch_level;
			end
		end

		if (claimed && (ev.frame_kind == {1'b0, cfg.saved_reply_code})
			&& (st.mode == MODE_QUIESCING)) begin
			st_nx.last_status = (ev.frame_length != 8'd0) ? ev.frame_first_byte
				: cfg.save_failed_code;
			st_nx.reply_seen  = 1'b1;
		end

		if (r_start) begin
			st_nx.shutdowns        = st.shutdowns + 16'd1;
			st_nx.reply_seen       = 1'b0;
			st_nx.last_status      = cfg.save_failed_code;
			st_nx.request_sent     = ev.send_ok;
			st_nx.phase_start_time = ev.now_time;
			res.quiesce_strobe     = 1'b1;
			if (ev.send_ok) res.message_out = MSG_SHUTDOWN;
		end

		if (q_abort || f_wake) begin
			st_nx.aborts = st.aborts + 16'd1;
		end
		if (q_abort || f_wake || a_wake) begin
			res.resume_strobe = 1'b1;
			if (ev.send_ok) res.message_out = q_abort ? MSG_ABORT : MSG_WAKE;
		end

		// first request may have been dropped: send it once more
		if (q_resend && ev.send_ok) begin
			st_nx.request_sent     = 1'b1;
			st_nx.phase_start_time = ev.now_time;
			res.message_out        = MSG_SHUTDOWN;
		end

		if (q_flush || q_tmo) begin
			st_nx.phase_start_time = ev.now_time;
			res.save_strobe        = 1'b1;
			if (ev.send_ok) res.message_out = MSG_SLEEP;
		end
		if (q_tmo) begin
			st_nx.save_tmo_cnt = st.save_tmo_cnt + 16'd1;
		end

		res.frame_claimed  = claimed;
		res.power_state    = mode_nx;
		res.save_status    = st_nx.last_status;
		res.shutdown_count = st_nx.shutdowns;
		res.abort_count    = st_nx.aborts;
		res.timeout_count  = st_nx.save_tmo_cnt;
	end

endmodule

[sv/power_switch_shutdown_sequencer.sv]
// top level of the power switch shutdown sequencer
// an accepted input beat reaches its result beat through the input register,
//   then the step logic into the result register
// throughput: one event per cycle, limited only by the result side taking beats
// reset: arst_n clears control state at once; the configuration and state registers
//   load their defaults, the mode returns to running and the switch state is seeded from RST_SWITCH
module power_switch_shutdown_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// event stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// now_time[31:0], switch_level[32], frame_kind[40:33], frame_length[48:41],
	// frame_first_byte[56:49], link_up[57], send_ok[58], tx_empty[59], zero pad
	input  logic [63:0] s_tdata,
	// action[1:0]
	input  logic [1:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// frame_claimed[0], message_out[3:1], quiesce_strobe[4], save_strobe[5],
	// resume_strobe[6], power_state[8:7], save_status[16:9],
	// shutdown_count[32:17], abort_count[48:33], timeout_count[64:49], zero pad
	output logic [71:0] m_tdata
);
	import pss_pkg::*;

	// configuration registers
	cfg_t    cfg_q;

	// sequencer state
	state_t  st_q;
	state_t  st_nx;
	state_t  st_d;

	// input stage
	logic    valid_s1;
	event_t  ev_s1;
	event_t  ev_in;

	// result stage
	logic    valid_s2;
	result_t res;
	result_t res_s2;

	logic    advance;
	logic    take_in;

	assign ev_in.action           = action_t'(s_tuser);
	assign ev_in.now_time         = s_tdata[31:0];
	assign ev_in.switch_level     = s_tdata[32];
	assign ev_in.frame_kind       = s_tdata[40:33];
	assign ev_in.frame_length     = s_tdata[48:41];
	assign ev_in.frame_first_byte = s_tdata[56:49];
	assign ev_in.link_up          = s_tdata[57];
	assign ev_in.send_ok          = s_tdata[58];
	assign ev_in.tx_empty         = s_tdata[59];

	// the stage moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take_in  = s_tvalid && s_tready;

	pss_step u_step (
		.ev    (ev_s1),
		.cfg   (cfg_q),
		.st    (st_q),
		.st_nx (st_nx),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				debounce_time:    RST_DEBOUNCE,
				save_timeout:     RST_SAVE_TMO,
				flush_timeout:    RST_FLUSH_TMO,
				saved_reply_code: RST_REPLY_CODE,
				save_failed_code: RST_FAILED_CODE
			};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:    cfg_q.debounce_time    <= cfg_data;
				CFG_SAVE_TMO:    cfg_q.save_timeout     <= cfg_data;
				CFG_FLUSH_TMO:   cfg_q.flush_timeout    <= cfg_data;
				CFG_REPLY_CODE:  cfg_q.saved_reply_code <= cfg_data[6:0];
				CFG_FAILED_CODE: cfg_q.save_failed_code <= cfg_data[7:0];
				// the seed only acts on the switch state below
				CFG_SWITCH_RST:  ;
				default: ;
			endcase
		end
	end

	// next state; a seed write also reloads the switch state
	always_comb begin
		st_d = st_q;
		if (advance) st_d = st_nx;
		if (cfg_we && (cfg_index == CFG_SWITCH_RST)) begin
			st_d.switch_stable   = cfg_data[0];
			st_d.switch_last_raw = cfg_data[0];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) valid_s2 <= 1'b1;
			else if (m_tready) valid_s2 <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) ev_s1 <= ev_in;
		if (advance) res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.timeout_count, res_s2.abort_count,
		res_s2.shutdown_count, res_s2.save_status, res_s2.power_state,
		res_s2.resume_strobe, res_s2.save_strobe, res_s2.quiesce_strobe,
		res_s2.message_out, res_s2.frame_claimed};

	// a quiesce strobe only comes with the step into quiescing
	a_quiesce_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.quiesce_strobe |-> res_s2.power_state == MODE_QUIESCING)
		else $error("quiesce strobe outside quiescing");

	// a save strobe only comes with the step into flushing
	a_save_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.save_strobe |-> res_s2.power_state == MODE_FLUSHING)
		else $error("save strobe outside flushing");

	// resume always lands in running
	a_resume_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.resume_strobe |-> res_s2.power_state == MODE_RUNNING)
		else $error("resume strobe outside running");

	// a stalled event in the input stage keeps the sequencer state untouched when no configuration write comes
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance && !cfg_we |=> st_q == $past(st_q))
		else $error("state moved without an event");

	// abort and wake strobes never come together with a quiesce strobe
	a_strobe_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.quiesce_strobe && res_s2.resume_strobe))
		else $error("quiesce and resume strobes together");

endmodule
